@@ rtl/crr_pkg.sv @@
package crr_pkg;

    // Configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ORIGIN_OFFSETS = 3'd0;
    localparam t_cfg_idx CFG_LEGACY_MODE    = 3'd1;
    localparam t_cfg_idx CFG_BEHAVIOR_FLAGS = 3'd2;
    localparam t_cfg_idx CFG_TURBO_SETUP    = 3'd3;
    localparam t_cfg_idx CFG_INVERT_MASK    = 3'd4;

    localparam int CFG_DATA_W = 64;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 64;

    // Behavior flag bit positions
    localparam int FLG_L_TO_C      = 0;
    localparam int FLG_C_TO_L      = 1;
    localparam int FLG_PAD_TO_L    = 2;
    localparam int FLG_PAD_TO_C    = 3;
    localparam int FLG_UNIFY_TRIG  = 4;
    localparam int FLG_NO_TRIGGERS = 5;
    localparam int FLG_NO_C_STICK  = 6;
    localparam int FLG_NO_L_STICK  = 7;

    // Turbo setup bit positions
    localparam int TRB_X_AS_A = 0;
    localparam int TRB_Y_AS_B = 1;

    // One report as eight bytes plus the turbo phase
    typedef struct packed {
        logic [2:0] turbo_phase;
        logic [7:0] raw_trigger_r;
        logic [7:0] raw_trigger_l;
        logic [7:0] raw_c_y;
        logic [7:0] raw_c_x;
        logic [7:0] raw_left_y;
        logic [7:0] raw_left_x;
        logic [7:0] raw_buttons_b;
        logic [7:0] raw_buttons_a;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_trigger_r;
        logic [7:0] out_trigger_l;
        logic [7:0] out_c_y;
        logic [7:0] out_c_x;
        logic [7:0] out_left_y;
        logic [7:0] out_left_x;
        logic [7:0] out_buttons_1;
        logic [7:0] out_buttons_0;
    } t_out_item;

    // Direction bits of a corrected stick byte: bit0 negative, bit1 positive
    function automatic logic [1:0] sign_bits(input logic [7:0] v);
        logic [1:0] s;
        if (v == 8'h00) begin
            s = 2'b00;
        end else if (v[7]) begin
            s = 2'b01;
        end else begin
            s = 2'b10;
        end
        return s;
    endfunction

    // Pad directions to a stick x byte: Left gives 0x80, Right 0x7f, both 0xff
    function automatic logic [7:0] pad_x(input logic [7:0] pad);
        return {pad[6], {7{pad[7]}}};
    endfunction

    // Pad directions to a stick y byte: Up gives 0x80, Down 0x7f, both 0xff
    function automatic logic [7:0] pad_y(input logic [7:0] pad);
        return {pad[4], {7{pad[5]}}};
    endfunction

endpackage

@@ rtl/controller_report_remapper.sv @@
// Controller report remapper.
// Slave stream: one beat is one raw 8-byte controller report plus a 3-bit
// turbo phase. Master stream: one beat is the remapped 8-byte report.
// Each byte of the analog section is corrected by its rest offset, then the
// buttons are packed either into the legacy pad byte (with turbo and stick
// direction bits) or into the extended two-byte layout with the behavior
// flags and the invert mask applied.
// An accepted beat passes from the input register to the result register.
// Throughput: one beat per cycle, set by the two-register pipeline; the
// slave side keeps accepting while a finished result waits, and stops only
// when both registers hold beats and the master side is stalled.
// Configuration is written through the write port; the user must write it
// only while the stream is idle, which the block does not enforce.
// Reset (synchronous, active low) empties both registers and loads the
// register defaults: legacy mode on, everything else zero.
module controller_report_remapper (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // raw_buttons_a, raw_buttons_b, raw_left_x, raw_left_y, raw_c_x,
    // raw_c_y, raw_trigger_l, raw_trigger_r, turbo_phase[2:0], 5 zero bits
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [crr_pkg::IN_DATA_W-1:0]        i_s_axis_tdata,
    // out_buttons_0, out_buttons_1, out_left_x, out_left_y, out_c_x,
    // out_c_y, out_trigger_l, out_trigger_r
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [crr_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    input  logic                                 i_cfg_we,
    input  crr_pkg::t_cfg_idx                    i_cfg_idx,
    input  logic [crr_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);

    logic [47:0]        r_origin_offsets;
    logic               r_legacy_mode;
    logic [7:0]         r_behavior_flags;
    logic [1:0]         r_turbo_setup;
    logic [63:0]        r_invert_mask;

    logic               r_s1_valid;
    crr_pkg::t_in_item  r_s1_item;
    logic               r_out_valid;
    crr_pkg::t_out_item r_out_item;
    crr_pkg::t_out_item n_out_item;

    logic               s2_ready;
    logic               s1_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_offsets <= '0;
            r_legacy_mode    <= 1'b1;
            r_behavior_flags <= '0;
            r_turbo_setup    <= '0;
            r_invert_mask    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                crr_pkg::CFG_ORIGIN_OFFSETS: r_origin_offsets <= i_cfg_wdata[47:0];
                crr_pkg::CFG_LEGACY_MODE:    r_legacy_mode    <= i_cfg_wdata[0];
                crr_pkg::CFG_BEHAVIOR_FLAGS: r_behavior_flags <= i_cfg_wdata[7:0];
                crr_pkg::CFG_TURBO_SETUP:    r_turbo_setup    <= i_cfg_wdata[1:0];
                crr_pkg::CFG_INVERT_MASK:    r_invert_mask    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline flow control
    assign s2_ready        = !r_out_valid || i_m_axis_tready;
    assign s1_ready        = !r_s1_valid || s2_ready;
    assign o_s_axis_tready = s1_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_s_axis_tvalid) begin
            r_s1_item <= crr_pkg::t_in_item'(i_s_axis_tdata[$bits(crr_pkg::t_in_item)-1:0]);
        end
    end

    // Remap one report
    always_comb begin
        logic [7:0] a;
        logic [7:0] bb;
        logic [7:0] lx, ly, cx, cy, tl, tr;
        logic [7:0] p0, p1;
        logic       fire;
        logic [7:0] f;

        a  = r_s1_item.raw_buttons_a;
        bb = r_s1_item.raw_buttons_b;
        f  = r_behavior_flags;
        lx = r_s1_item.raw_left_x    - r_origin_offsets[7:0];
        ly = r_s1_item.raw_left_y    - r_origin_offsets[15:8];
        cx = r_s1_item.raw_c_x       - r_origin_offsets[23:16];
        cy = r_s1_item.raw_c_y       - r_origin_offsets[31:24];
        tl = r_s1_item.raw_trigger_l - r_origin_offsets[39:32];
        tr = r_s1_item.raw_trigger_r - r_origin_offsets[47:40];
        fire = (r_s1_item.turbo_phase == 3'd0);

        if (r_legacy_mode) begin
            p0 = {bb[1:0], bb[2], bb[3], a[4], bb[4], a[1:0]};
            p0[0] = p0[0] | (r_turbo_setup[crr_pkg::TRB_X_AS_A] & a[2] & fire);
            p0[1] = p0[1] | (r_turbo_setup[crr_pkg::TRB_Y_AS_B] & a[3] & fire);
            p0[7:6] = p0[7:6] | crr_pkg::sign_bits(lx);
            p0[5:4] = p0[5:4] | crr_pkg::sign_bits(ly);
            p1 = bb;
        end else begin
            p0 = {bb[1:0], bb[2], bb[3], a[4], bb[4], a[3], a[1]};
            p1 = {4'b0000, bb[5], bb[6], a[2], a[0]};

            // stick copy, left to C has priority
            if (f[crr_pkg::FLG_L_TO_C]) begin
                if (cx == 8'h00 && cy == 8'h00) begin
                    cx = lx;
                    cy = ly;
                end
            end else if (f[crr_pkg::FLG_C_TO_L]) begin
                if (lx == 8'h00 && ly == 8'h00) begin
                    lx = cx;
                    ly = cy;
                end
            end
            if (f[crr_pkg::FLG_PAD_TO_L]) begin
                lx = crr_pkg::pad_x(p0);
                ly = crr_pkg::pad_y(p0);
            end
            if (f[crr_pkg::FLG_PAD_TO_C]) begin
                cx = crr_pkg::pad_x(p0);
                cy = crr_pkg::pad_y(p0);
            end
            if (f[crr_pkg::FLG_UNIFY_TRIG]) begin
                if (tr > tl) begin
                    tl = tr;
                end
                tr = 8'h00;
            end
            // zero regions: triggers, C stick, left stick
            if (f[crr_pkg::FLG_NO_TRIGGERS]) begin
                tl = 8'h00;
                tr = 8'h00;
            end
            if (f[crr_pkg::FLG_NO_C_STICK]) begin
                cx = 8'h00;
                cy = 8'h00;
            end
            if (f[crr_pkg::FLG_NO_L_STICK]) begin
                lx = 8'h00;
                ly = 8'h00;
            end
            p0 = p0 ^ r_invert_mask[7:0];
            p1 = p1 ^ r_invert_mask[15:8];
            lx = lx ^ r_invert_mask[23:16];
            ly = ly ^ r_invert_mask[31:24];
            cx = cx ^ r_invert_mask[39:32];
            cy = cy ^ r_invert_mask[47:40];
            tl = tl ^ r_invert_mask[55:48];
            tr = tr ^ r_invert_mask[63:56];
        end

        n_out_item.out_buttons_0 = p0;
        n_out_item.out_buttons_1 = p1;
        n_out_item.out_left_x    = lx;
        n_out_item.out_left_y    = ly;
        n_out_item.out_c_x       = cx;
        n_out_item.out_c_y       = cy;
        n_out_item.out_trigger_l = tl;
        n_out_item.out_trigger_r = tr;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_item;

    // Slave side stalls only with both registers full
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_s1_valid && r_out_valid && !i_m_axis_tready))
        else $error("slave side stalled with room in the pipeline");

    // A beat in the input register moves on when the result register frees up
    a_s1_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s2_ready) |=> o_m_axis_tvalid)
        else $error("beat lost between input and result registers");

    // Nothing is presented right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_m_axis_tvalid && !r_s1_valid))
        else $error("pipeline not empty after reset");

endmodule
